FILE: rtl/core/iac_pkg.sv
// Package for the intrusion alarm controller: modes, register indexes, timing constants.
package iac_pkg;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_EXIT     = 2'd1,
    MODE_ARMED    = 2'd2,
    MODE_ALARM    = 2'd3
  } mode_e;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_EXIT_DELAY   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_TIMEOUT  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_ALERT_REPEAT = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_BLINK_HALF   = 8'd3;

  localparam logic [15:0] EXIT_DELAY_RST   = 16'd10000;
  localparam logic [15:0] KEY_TIMEOUT_RST  = 16'd3000;
  localparam logic [17:0] ALERT_REPEAT_RST = 18'd60000;
  localparam logic [9:0]  BLINK_HALF_RST   = 10'd300;

  localparam logic [10:0] SIREN_CYCLE = 11'd1600;
  localparam logic [10:0] BEEP1_END   = 11'd300;
  localparam logic [10:0] BEEP2_START = 11'd500;
  localparam logic [10:0] BEEP2_END   = 11'd800;

  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_1    = 2'd1;
  localparam logic [1:0] KEY_2    = 2'd2;
  localparam logic [1:0] KEY_3    = 2'd3;

endpackage

FILE: rtl/core/intrusion_alarm_controller_top.sv
// Intrusion alarm controller: one tick word in, one status word out.
//
// Channel   Dir  Handshake              Contents
// s_axis    in   s_axis_tvalid/tready   tick word: key, motion, link
// m_axis    out  m_axis_tvalid/tready   status word: mode, LEDs, siren, alert pulses
// cfg       in   cfg_valid_i/ready_o    register index and write data
//
// One word per cycle sustained while m_axis_tready is high; a word passes the input
// register, then the rule logic into the output register, which updates controller state.
// Reset clears control state and loads defaults, not entries or data; no clearing pass.
// A stalled output holds the output register; the input register still takes
// one more word, then s_axis_tready drops until the output is taken.
module intrusion_alarm_controller_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // key_press[1:0], motion, link_up
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // alarm_mode[1:0], armed_led, disarmed_led, siren_on, send_first_alert, send_repeat_alert
  output logic [7:0]                      m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [iac_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [iac_pkg::CfgDataW-1:0]    cfg_data_i
);
  import iac_pkg::*;

  // configuration
  logic [15:0] exit_delay_q, key_timeout_q;
  logic [17:0] alert_repeat_q;
  logic [9:0]  blink_half_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exit_delay_q   <= EXIT_DELAY_RST;
      key_timeout_q  <= KEY_TIMEOUT_RST;
      alert_repeat_q <= ALERT_REPEAT_RST;
      blink_half_q   <= BLINK_HALF_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_EXIT_DELAY:   exit_delay_q   <= cfg_data_i[15:0];
        REG_KEY_TIMEOUT:  key_timeout_q  <= cfg_data_i[15:0];
        REG_ALERT_REPEAT: alert_repeat_q <= cfg_data_i[17:0];
        REG_BLINK_HALF:   blink_half_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  logic [3:0] in_word_q;
  logic       advance;
  logic       out_valid_q;
  logic [6:0] out_word_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata[3:0];
    end
  end

  // controller state
  mode_e       mode_q, mode_d;
  logic [1:0]  entry0_q, entry1_q, entry0_d, entry1_d;
  logic [1:0]  count_q, count_d;
  logic        pending_q, pending_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] exit_q, exit_d;
  logic [9:0]  blink_q, blink_d;
  logic        level_q, level_d;
  logic [10:0] phase_q, phase_d;
  logic        done_q, done_d;
  logic [17:0] alert_q, alert_d;
  logic        first, repeat_al, siren, led;
  logic [1:0]  key;
  logic        motion, link;

  assign key    = in_word_q[1:0];
  assign motion = in_word_q[2];
  assign link   = in_word_q[3];

  always_comb begin
    mode_d    = mode_q;
    entry0_d  = entry0_q;
    entry1_d  = entry1_q;
    count_d   = count_q;
    pending_d = pending_q;
    idle_d    = idle_q;
    exit_d    = exit_q;
    blink_d   = blink_q;
    level_d   = level_q;
    phase_d   = phase_q;
    done_d    = done_q;
    alert_d   = alert_q;
    first     = 1'b0;
    repeat_al = 1'b0;

    // timers: idle, exit, blink and alert saturate; the siren phase wraps at SIREN_CYCLE
    if (pending_d && idle_d != '1) idle_d = idle_d + 16'd1;
    if (mode_d == MODE_EXIT) begin
      if (exit_d != '1)  exit_d  = exit_d + 16'd1;
      if (blink_d != '1) blink_d = blink_d + 10'd1;
    end
    if (mode_d == MODE_ALARM) begin
      phase_d = (phase_d + 11'd1 >= SIREN_CYCLE) ? 11'd0 : phase_d + 11'd1;
      if (done_d && alert_d != '1) alert_d = alert_d + 18'd1;
    end

    // key rule
    if (key != KEY_NONE) begin
      if (pending_d && idle_d > key_timeout_q) count_d = 2'd0;
      pending_d = 1'b1;
      idle_d    = 16'd0;
      case (count_d)
        2'd0: begin
          entry0_d = key;
          count_d  = 2'd1;
        end
        2'd1: begin
          entry1_d = key;
          count_d  = 2'd2;
        end
        default: begin
          // third key completes the code
          if (entry0_d == KEY_1 && entry1_d == KEY_2 && key == KEY_3 &&
              mode_d == MODE_DISARMED) begin
            mode_d  = MODE_EXIT;
            exit_d  = 16'd0;
            blink_d = 10'd0;
            level_d = 1'b1;
            phase_d = 11'd0;
          end
          if (entry0_d == KEY_3 && entry1_d == KEY_2 && key == KEY_1) begin
            mode_d  = MODE_DISARMED;
            phase_d = 11'd0;
            done_d  = 1'b0;
          end
          count_d   = 2'd0;
          pending_d = 1'b0;
          idle_d    = 16'd0;
        end
      endcase
    end

    // exit delay rule
    if (mode_d == MODE_EXIT) begin
      if (blink_d >= blink_half_q) begin
        blink_d = 10'd0;
        level_d = !level_d;
      end
      if (exit_d >= exit_delay_q) begin
        mode_d  = MODE_ARMED;
        phase_d = 11'd0;
        done_d  = 1'b0;
      end
    end

    // motion rule
    if (mode_d == MODE_ARMED && motion) mode_d = MODE_ALARM;

    // alarm rule
    if (mode_d == MODE_ALARM) begin
      if (!done_d && link) begin
        first   = 1'b1;
        done_d  = 1'b1;
        alert_d = 18'd0;
      end
      if (link && done_d && alert_d > alert_repeat_q) begin
        repeat_al = 1'b1;
        alert_d   = 18'd0;
      end
    end

    case (mode_d)
      MODE_DISARMED: led = 1'b0;
      MODE_EXIT:     led = level_d;
      default:       led = 1'b1;
    endcase
    siren = (mode_d == MODE_ALARM) &&
            (phase_d < BEEP1_END || (phase_d >= BEEP2_START && phase_d < BEEP2_END));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_DISARMED;
      count_q   <= 2'd0;
      pending_q <= 1'b0;
      idle_q    <= 16'd0;
      exit_q    <= 16'd0;
      blink_q   <= 10'd0;
      level_q   <= 1'b0;
      phase_q   <= 11'd0;
      done_q    <= 1'b0;
      alert_q   <= 18'd0;
    end else if (advance) begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      pending_q <= pending_d;
      idle_q    <= idle_d;
      exit_q    <= exit_d;
      blink_q   <= blink_d;
      level_q   <= level_d;
      phase_q   <= phase_d;
      done_q    <= done_d;
      alert_q   <= alert_d;
    end
  end

  // code entries are only read after being written
  always_ff @(posedge clk_i) begin
    if (advance) begin
      entry0_q <= entry0_d;
      entry1_q <= entry1_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= {repeat_al, first, siren, (mode_d == MODE_DISARMED), led, mode_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_word_q};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("code count out of range");

  a_alert_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[5] || m_axis_tdata[6])) |-> m_axis_tdata[1:0] == MODE_ALARM)
    else $error("alert pulse outside alarm mode");

  a_alert_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[5] && m_axis_tdata[6]))
    else $error("first and repeat alert together");

  a_pending_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != 2'd0) |-> pending_q) else $error("partial code without pending flag");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q) else $error("input word lost while stalled");
`endif

endmodule
